// ----- design/sfv_pkg.sv -----
// shared types and constants for the sensor frame validator
`timescale 1ns / 1ps
package sfv_pkg;

  localparam int unsigned FrameLen = 13;
  localparam logic [3:0] FrameLenCount = 4'd13;
  localparam logic [3:0] CountMax = 4'd15;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_SUM   = 3'd3,
    ST_RANGE     = 3'd4,
    ST_STALE     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_MAGIC    = 2'd0,
    REG_VLIMIT   = 2'd1,
    REG_CLIMIT   = 2'd2,
    REG_STALE    = 2'd3
  } reg_idx_t;

  // event handed from the front part to the back part
  typedef struct packed {
    logic        is_tick;
    status_t     status;
    logic [15:0] sequence_num;
    logic [31:0] voltage;
    logic [31:0] current;
  } event_t;

  typedef struct packed {
    status_t     status;
    logic        data_valid;
    logic [15:0] sequence_out;
    logic [31:0] voltage_out;
    logic [31:0] current_out;
    logic [31:0] power_out;
  } result_t;

  // a orders below b as ieee singles (false if either is nan)
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic an, bn, az;
    an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    az = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (an || bn || az) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

endpackage

// ----- design/sfv_front.sv -----
// front part: frame assembly, checksum and frame checks
`timescale 1ns / 1ps
module sfv_front
  import sfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        cmd,
  input  logic [7:0]  byte_value,
  input  logic        frame_end,
  input  logic [15:0] magic_bytes,
  input  logic [31:0] voltage_limit,
  input  logic [31:0] current_limit,
  input  logic        ev_ready,
  output logic        ev_valid,
  output event_t      ev
);

  logic [3:0]  byte_count;
  logic [7:0]  xor_acc;
  logic [7:0]  frame_bytes [FrameLen];
  logic [7:0]  b [FrameLen];
  logic [31:0] v, c;
  status_t     st;

  // view of the frame including the byte arriving now
  always_comb begin
    for (int i = 0; i < FrameLen; i++) begin
      b[i] = (byte_count == 4'(i)) ? byte_value : frame_bytes[i];
    end
    v = {b[7], b[6], b[5], b[4]};
    c = {b[11], b[10], b[9], b[8]};
    if (byte_count != FrameLenCount - 4'd1) st = ST_BAD_LEN;
    else if (b[0] != magic_bytes[7:0] || b[1] != magic_bytes[15:8]) st = ST_BAD_MAGIC;
    else if (b[12] != xor_acc) st = ST_BAD_SUM;
    else if (f_lt(v, 32'd0) || f_lt(voltage_limit, v) ||
             f_lt(c, 32'd0) || f_lt(current_limit, c)) st = ST_RANGE;
    else st = ST_ACCEPTED;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !cmd) begin
      for (int i = 0; i < FrameLen; i++) begin
        if (byte_count == 4'(i)) frame_bytes[i] <= byte_value;
      end
    end
    // event register holds while the back part cannot take it
    if (!ev_valid || ev_ready) begin
      ev.is_tick      <= cmd;
      ev.status       <= st;
      ev.sequence_num <= {b[3], b[2]};
      ev.voltage      <= v;
      ev.current      <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      xor_acc    <= '0;
      ev_valid   <= 1'b0;
    end else begin
      if (!ev_valid || ev_ready) ev_valid <= in_valid && (cmd || frame_end);
      if (in_valid && !cmd) begin
        if (frame_end) begin
          byte_count <= '0;
          xor_acc    <= '0;
        end else begin
          if (byte_count < FrameLenCount - 4'd1) xor_acc <= xor_acc ^ byte_value;
          if (byte_count < CountMax) byte_count <= byte_count + 4'd1;
        end
      end
    end
  end

endmodule

// ----- design/sfv_fmul.sv -----
// two-stage ieee single multiplier, round to nearest even
`timescale 1ns / 1ps
module sfv_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  // stage 1: special cases, mantissa product
  logic        s1_sign, s1_special, s1_zero;
  logic [31:0] s1_spec_val;
  logic [47:0] s1_prod;
  logic signed [10:0] s1_exp;

  logic [30:0] am, bm;
  logic [23:0] ma, mb;
  logic signed [10:0] ea, eb;
  logic [4:0]  lza, lzb;
  logic [23:0] na, nb;

  always_comb begin
    am = a[30:0];
    bm = b[30:0];
    ma = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    mb = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
    lza = '0;
    lzb = '0;
    for (int i = 0; i < 24; i++) begin
      if (ma[i]) lza = 5'(23 - i);
      if (mb[i]) lzb = 5'(23 - i);
    end
    na = ma << lza;
    nb = mb << lzb;
    ea = ((a[30:23] == 8'd0) ? 11'sd1 : $signed({3'b0, a[30:23]})) - $signed({6'b0, lza});
    eb = ((b[30:23] == 8'd0) ? 11'sd1 : $signed({3'b0, b[30:23]})) - $signed({6'b0, lzb});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign <= a[31] ^ b[31];
      s1_prod <= na * nb;
      s1_exp  <= ea + eb - 11'sd127;
      s1_zero <= (am == 31'd0) || (bm == 31'd0);
      if (am > 31'h7F800000) begin
        s1_special  <= 1'b1;
        s1_spec_val <= a | 32'h0040_0000;
      end else if (bm > 31'h7F800000) begin
        s1_special  <= 1'b1;
        s1_spec_val <= b | 32'h0040_0000;
      end else if ((am == 31'h7F800000 && bm == 31'd0) ||
                   (bm == 31'h7F800000 && am == 31'd0)) begin
        s1_special  <= 1'b1;
        s1_spec_val <= 32'h7FC0_0000;
      end else if (am == 31'h7F800000 || bm == 31'h7F800000) begin
        s1_special  <= 1'b1;
        s1_spec_val <= {a[31] ^ b[31], 31'h7F800000};
      end else begin
        s1_special <= 1'b0;
      end
    end
  end

  // stage 2: normalize, round
  logic [47:0] pn;
  logic signed [11:0] e;
  logic [8:0]  sh;
  logic [49:0] ext;
  logic [23:0] m;
  logic        g, st;
  logic [24:0] mr;
  logic signed [11:0] er;
  logic [31:0] res;

  always_comb begin
    pn = s1_prod[47] ? s1_prod : (s1_prod << 1);
    e  = 12'(s1_exp) + (s1_prod[47] ? 12'sd1 : 12'sd0);
    // below normal range: shift right into a denormal
    sh  = (e < 12'sd1) ? ((e < -12'sd30) ? 9'd31 : 9'(12'sd1 - e)) : 9'd0;
    ext = {pn, 2'b00} >> sh;
    st  = ((({pn, 2'b00} << (9'd50 - sh)) != 50'd0) && sh != 9'd0) || (ext[24:0] != 25'd0);
    m   = ext[49:26];
    g   = ext[25];
    mr  = {1'b0, m} + ((g && (st || m[0])) ? 25'd1 : 25'd0);
    er  = (e < 12'sd1) ? 12'sd0 : e;
    if (mr[24]) begin
      mr = mr >> 1;
      er = er + 12'sd1;
    end else if (er == 12'sd0 && mr[23]) begin
      er = 12'sd1;
    end
    if (s1_special) res = s1_spec_val;
    else if (s1_zero) res = {s1_sign, 31'd0};
    else if (er >= 12'sd255) res = {s1_sign, 31'h7F800000};
    else res = {s1_sign, er[7:0], mr[22:0]};
  end

  assign p = res;

endmodule

// ----- design/sfv_back.sv -----
// back part: latches accepted data, ages it, builds results
`timescale 1ns / 1ps
module sfv_back
  import sfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        ev_valid,
  input  event_t      ev,
  output logic        ev_ready,
  input  logic [15:0] stale_ticks,
  output logic        res_valid,
  output result_t     res,
  input  logic        res_ready
);

  // pipeline: p1 holds event while the multiplier works, then result slot
  logic        p1_valid;
  event_t      p1;
  logic [31:0] prod;
  logic        adv;

  logic        valid_flag;
  logic [15:0] age_ticks;
  logic [15:0] lseq;
  logic [31:0] lv, lc, lp;

  // first multiplier stage loads together with p1
  sfv_fmul u_mul (.clk(clk), .en(ev_valid && ev_ready), .a(ev.voltage), .b(ev.current),
                  .p(prod));

  assign adv      = !res_valid || res_ready;
  assign ev_ready = !p1_valid || adv;

  logic [15:0] age_inc;
  logic        emit;
  assign age_inc = (age_ticks != 16'hFFFF) ? age_ticks + 16'd1 : age_ticks;
  assign emit = !p1.is_tick || (valid_flag && age_inc >= stale_ticks);

  always_ff @(posedge clk) begin
    if (ev_valid && ev_ready) p1 <= ev;
    if (p1_valid && adv) begin
      if (p1.is_tick) begin
        res.status       <= ST_STALE;
        res.data_valid   <= 1'b0;
        res.sequence_out <= lseq;
        res.voltage_out  <= lv;
        res.current_out  <= lc;
        res.power_out    <= lp;
      end else if (p1.status == ST_ACCEPTED) begin
        res.status       <= p1.status;
        res.data_valid   <= 1'b1;
        res.sequence_out <= p1.sequence_num;
        res.voltage_out  <= p1.voltage;
        res.current_out  <= p1.current;
        res.power_out    <= prod;
      end else begin
        res.status       <= p1.status;
        res.data_valid   <= valid_flag;
        res.sequence_out <= lseq;
        res.voltage_out  <= lv;
        res.current_out  <= lc;
        res.power_out    <= lp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid   <= 1'b0;
      res_valid  <= 1'b0;
      valid_flag <= 1'b0;
      age_ticks  <= '0;
      lseq <= '0;
      lv   <= '0;
      lc   <= '0;
      lp   <= '0;
    end else begin
      if (ev_ready) p1_valid <= ev_valid;
      if (adv) res_valid <= p1_valid && emit;
      if (p1_valid && adv) begin
        if (p1.is_tick) begin
          if (valid_flag) begin
            age_ticks <= age_inc;
            if (age_inc >= stale_ticks) valid_flag <= 1'b0;
          end
        end else if (p1.status == ST_ACCEPTED) begin
          valid_flag <= 1'b1;
          age_ticks  <= '0;
          lseq <= p1.sequence_num;
          lv   <= p1.voltage;
          lc   <= p1.current;
          lp   <= prod;
        end
      end
    end
  end

endmodule

// ----- design/sensor_frame_validator.sv -----
// top level of the sensor frame validator
`timescale 1ns / 1ps
// Takes one byte or tick request per cycle, back to back, as long as results
// are taken. A frame result reaches the output through registers: the frame
// checks are registered with its last byte, the first multiplier stage with
// the event stage, and rounding lands in the output register. Ticks that make
// the data go stale give a stale result; other ticks and non-final bytes give
// none. Backpressure on the output reaches the input through the event
// register, a one-entry event stage and the output register.
module sensor_frame_validator
  import sfv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // byte_value
  input  logic         s_tuser,   // cmd
  input  logic         s_tlast,   // frame_end
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], data_valid[3], sequence_out[19:4], voltage_out[51:20],
  // current_out[83:52], power_out[115:84], zero fill
  output logic [119:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] magic_bytes, stale_ticks;
  logic [31:0] voltage_limit, current_limit;
  logic        ev_valid, ev_ready;
  event_t      ev;
  result_t     res;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_bytes   <= 16'hFECA;
      voltage_limit <= 32'h43FA0000;
      current_limit <= 32'h42C80000;
      stale_ticks   <= 16'd5000;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_MAGIC:  magic_bytes   <= pwdata[15:0];
        REG_VLIMIT: voltage_limit <= pwdata;
        REG_CLIMIT: current_limit <= pwdata;
        REG_STALE:  stale_ticks   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MAGIC:  prdata = {16'd0, magic_bytes};
      REG_VLIMIT: prdata = voltage_limit;
      REG_CLIMIT: prdata = current_limit;
      REG_STALE:  prdata = {16'd0, stale_ticks};
      default:    prdata = '0;
    endcase
  end

  // front stalls only when its event register cannot move on
  logic front_hold;
  assign front_hold = ev_valid && !ev_ready;
  assign s_tready   = !front_hold;

  sfv_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid && s_tready && !front_hold),
    .cmd(s_tuser), .byte_value(s_tdata), .frame_end(s_tlast),
    .magic_bytes(magic_bytes), .voltage_limit(voltage_limit),
    .current_limit(current_limit), .ev_ready(ev_ready), .ev_valid(ev_valid), .ev(ev)
  );

  sfv_back u_back (
    .clk(clk), .rst(rst), .ev_valid(ev_valid), .ev(ev), .ev_ready(ev_ready),
    .stale_ticks(stale_ticks), .res_valid(m_tvalid), .res(res), .res_ready(m_tready)
  );

  assign m_tdata = {4'd0, res.power_out, res.current_out, res.voltage_out,
                    res.sequence_out, res.data_valid, res.status};

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= 3'd5) else $error("bad status");
  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] == 3'd0) |-> m_tdata[3]) else $error("accept without valid");
  a_stale_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] == 3'd5) |-> !m_tdata[3]) else $error("stale keeps valid");

endmodule
